// ===== hdl/skc_pkg.sv =====
// Shared types and constants of the linked stereo compressor.
package skc_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 24;
  localparam int LOG_TABLE_DEPTH_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [14:0] DB_FLOOR = 15'd25600;
  localparam logic [31:0] DB_PER_LOG2 = 32'd101008905;
  localparam logic [31:0] LOG2_PER_DB = 32'd2786635;

  localparam logic [14:0] THRESHOLD_RESET = 15'(-4608);
  localparam logic [15:0] RATIO_RESET = 16'd49152;
  localparam logic [11:0] KNEE_RESET = 12'd1536;
  localparam logic [15:0] ATTACK_RESET = 16'd65400;
  localparam logic [15:0] RELEASE_RESET = 16'd65527;
  localparam logic [15:0] MAKEUP_RESET = 16'd4096;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_RATIO     = 3'd1,
    REG_KNEE      = 3'd2,
    REG_ATTACK    = 3'd3,
    REG_RELEASE   = 3'd4,
    REG_MAKEUP    = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [14:0] threshold_db;
    logic [15:0] ratio_slope;
    logic [11:0] knee_width_db;
    logic [15:0] attack_coeff;
    logic [15:0] release_coeff;
    logic [15:0] makeup_gain;
  } cfg_t;

endpackage

// ===== hdl/soft_knee_linked_stereo_compressor.sv =====
// Top level of the soft-knee linked stereo compressor.
//
// Input stream s_*: one stereo pair per request, left and right signed samples.
// Output stream m_*: gain-applied left and right, saturated, and the present
// envelope gain reduction in 1/256 dB (25600 at the -100 dB floor).
// Registers are written through cfg_we / cfg_index / cfg_data while idle;
// unknown indexes are ignored.
// From input accept to output valid a pair passes the input register, the queue
// and the engine: all multiplications share one 32x32 multiplier, the level
// detector runs twice (peak, then envelope, each skipped at zero), the knee
// divider takes 12 steps, and the exponent takes one product per set fraction
// bit (up to 16). One pair is processed at a time; the next is taken the cycle
// after the previous one leaves the engine.
// An input register and a two-entry queue keep s_tready high while a result
// waits; when the receiver stalls, the result holds in the output register and
// the engine waits at completion, then the queue fills and s_tready drops.
// Reset restores register defaults and zeroes the envelope, so output is muted
// until the envelope rises.
module soft_knee_linked_stereo_compressor
  import skc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEFAULT
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // left_sample, right_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // left_out, right_out, gain_reduction_db
  output logic [((2*SAMPLE_BITS+15+7)/8)*8-1:0]      m_tdata,
  input  logic                                       cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]                  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]                   cfg_data
);

  localparam int QW = 3 * SAMPLE_BITS + 2;
  localparam int OW = ((2 * SAMPLE_BITS + 15 + 7) / 8) * 8;

  cfg_t                   cfg;
  logic                   fq_valid;
  logic                   fq_ready;
  logic [QW-1:0]          fq_data;
  logic                   qc_valid;
  logic                   qc_ready;
  logic [QW-1:0]          qc_data;
  logic [SAMPLE_BITS-1:0] left_out;
  logic [SAMPLE_BITS-1:0] right_out;
  logic [14:0]            gr_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_db <= THRESHOLD_RESET;
      cfg.ratio_slope <= RATIO_RESET;
      cfg.knee_width_db <= KNEE_RESET;
      cfg.attack_coeff <= ATTACK_RESET;
      cfg.release_coeff <= RELEASE_RESET;
      cfg.makeup_gain <= MAKEUP_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold_db <= cfg_data[14:0];
        REG_RATIO:     cfg.ratio_slope <= cfg_data;
        REG_KNEE:      cfg.knee_width_db <= cfg_data[11:0];
        REG_ATTACK:    cfg.attack_coeff <= cfg_data;
        REG_RELEASE:   cfg.release_coeff <= cfg_data;
        REG_MAKEUP:    cfg.makeup_gain <= cfg_data;
        default:       cfg <= cfg;
      endcase
    end
  end

  skc_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .left_sample(s_tdata[SAMPLE_BITS-1:0]),
    .right_sample(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .q_valid(fq_valid),
    .q_ready(fq_ready),
    .q_data(fq_data)
  );

  skc_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .in_valid(fq_valid),
    .in_ready(fq_ready),
    .in_data(fq_data),
    .out_valid(qc_valid),
    .out_ready(qc_ready),
    .out_data(qc_data)
  );

  skc_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(qc_valid),
    .q_ready(qc_ready),
    .q_data(qc_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .left_out(left_out),
    .right_out(right_out),
    .gr_out(gr_out)
  );

  assign m_tdata = OW'({gr_out, right_out, left_out});

endmodule

// ===== hdl/skc_front.sv =====
// Input stage: takes a stereo request, forms magnitudes and the linked peak.
module skc_front
  import skc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [SAMPLE_BITS-1:0]     left_sample,
  input  logic [SAMPLE_BITS-1:0]     right_sample,
  output logic                       q_valid,
  input  logic                       q_ready,
  output logic [3*SAMPLE_BITS+1:0]   q_data
);

  logic                   hold_v;
  logic [SAMPLE_BITS-1:0] mag_l;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [SAMPLE_BITS-1:0] peak;

  always_comb begin
    mag_l = left_sample[SAMPLE_BITS-1] ? (~left_sample + 1'b1) : left_sample;
    mag_r = right_sample[SAMPLE_BITS-1] ? (~right_sample + 1'b1) : right_sample;
    peak = (mag_l > mag_r) ? mag_l : mag_r;
  end

  assign in_ready = !hold_v || q_ready;
  assign q_valid = hold_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_v <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_v <= 1'b1;
    end else if (q_ready) begin
      hold_v <= 1'b0;
    end
  end

  // layout from lsb: peak, left magnitude, left sign, right magnitude, right sign
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_data <= {right_sample[SAMPLE_BITS-1], mag_r, left_sample[SAMPLE_BITS-1], mag_l, peak};
    end
  end

endmodule

// ===== hdl/skc_queue.sv =====
// Short queue between the input stage and the gain engine.
module skc_queue
  import skc_pkg::*;
#(
  parameter int WIDTH = 3 * SAMPLE_BITS_DEFAULT + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready = (count != CW'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_data;
    end
  end

endmodule

// ===== hdl/skc_core.sv =====
// Gain engine: level detect, gain computer, envelope and output scaling on one multiplier.
module skc_core
  import skc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
  parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  logic [3*SAMPLE_BITS+1:0] q_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SAMPLE_BITS-1:0]   left_out,
  output logic [SAMPLE_BITS-1:0]   right_out,
  output logic [14:0]              gr_out
);

  localparam int SB = SAMPLE_BITS;
  localparam int NW = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
  localparam int RW = $clog2(LOG_TABLE_DEPTH + 1);
  localparam logic [37:0] PMAX = 38'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  typedef enum logic [5:0] {
    IDLE, L_NORM, L_POS, L_IDX, L_RD1, L_INT, L_FRAC, L_DB, L_CLAMP,
    G_DIFF, G_SEL, K_SQ, K_S, K_DIVI, K_DIV, H_MUL, H_RES,
    T_MUL, T_SPLIT, E_STEP, E_ACC, E_SHIFT,
    V_C, V_M1, V_M2, V_SUM, V_TOT, V_TOTR,
    O_L, O_R, O_RD, DONE
  } state_t;

  function automatic logic [16:0] log_frac(input logic [63:0] y0);
    logic [63:0] y;
    logic [16:0] acc;
    y = y0;
    acc = '0;
    for (int k = 0; k < 16; k++) begin
      y = (y * y) >> 30;
      acc = {acc[15:0], 1'b0};
      if (y >= 64'h8000_0000) begin
        acc[0] = 1'b1;
        y = y >> 1;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v0);
    logic [63:0] v;
    logic [63:0] root;
    logic [63:0] b;
    v = v0;
    root = '0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] exp_factor(input int k);
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int j = 0; j < 16; j++) begin
      if (j < k) begin
        c = isqrt64(c << 30);
      end
    end
    return c;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat_out(input logic [63:0] p, input logic neg);
    logic [37:0] q;
    q = 38'(p[63:16]) + 38'(p[15]);
    if (neg) begin
      return (q > PMAX + 1'b1) ? SB'(PMAX + 1'b1) : SB'(~q + 1'b1);
    end
    return (q > PMAX) ? SB'(PMAX) : SB'(q);
  endfunction

  logic [16:0] log_tab [LOG_TABLE_DEPTH+1];
  logic [29:0] exp_tab [16];

  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_log
    localparam logic [63:0] Y0 =
      ((64'(LOG_TABLE_DEPTH) + 64'(gi)) << 30) / LOG_TABLE_DEPTH;
    assign log_tab[gi] = log_frac(Y0);
  end
  assign log_tab[LOG_TABLE_DEPTH] = 17'd65536;

  for (genvar gi = 0; gi < 16; gi++) begin : g_exp
    assign exp_tab[gi] = 30'(exp_factor(gi));
  end

  state_t        state;
  logic          pass;
  logic [SB-1:0] magl_r;
  logic [SB-1:0] magr_r;
  logic          lsign_r;
  logic          rsign_r;
  logic [NW-1:0] norm;
  logic [4:0]    e_r;
  logic [RW-1:0] idx_r;
  logic [RW-1:0] rom_addr;
  logic [31:0]   rem_r;
  logic [16:0]   rom_q;
  logic [16:0]   lo_r;
  logic [20:0]   a_r;
  logic [14:0]   atten_r;
  logic signed [17:0] d_r;
  logic [12:0]   u_r;
  logic [43:0]   num_r;
  logic [43:0]   div_r;
  logic [11:0]   quo_r;
  logic [3:0]    cnt_r;
  logic [14:0]   gr_r;
  logic [4:0]    n_r;
  logic [15:0]   f_r;
  logic [3:0]    k_r;
  logic [30:0]   g_r;
  logic [16:0]   tg_r;
  logic [15:0]   c_r;
  logic [33:0]   acc_r;
  logic [16:0]   env;
  logic [20:0]   total_r;
  logic [SB-1:0] left_r;
  logic [SB-1:0] right_r;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [63:0]   prod;

  logic [SB-1:0] q_peak;
  logic [31:0]   x_frac;
  logic [17:0]   frac;
  logic [20:0]   base;
  logic [32:0]   db_val;
  logic signed [17:0] d_next;
  logic signed [19:0] u_val;
  logic [19:0]   two_w;
  logic          knee;
  logic          hard;
  logic          div_ge;
  logic [21:0]   g2;
  logic [5:0]    rnd_sh;
  logic [39:0]   tg_tmp;

  assign q_peak = q_data[SB-1:0];
  assign q_ready = (state == IDLE);
  assign x_frac = {norm[NW-2:0], {(33 - NW){1'b0}}};

  always_comb begin
    frac = 18'(lo_r) + 18'(prod[63:32]);
    base = {e_r, 16'b0};
    db_val = 33'(prod[63:32]) + 33'(prod[31]);
    d_next = -$signed({3'b000, atten_r}) - $signed({{3{cfg.threshold_db[14]}}, cfg.threshold_db});
    u_val = $signed({d_r[17], d_r, 1'b0}) + $signed({8'b0, cfg.knee_width_db});
    two_w = {7'b0, cfg.knee_width_db, 1'b0};
    knee = (cfg.knee_width_db != '0) && !u_val[19] && (u_val <= $signed(two_w));
    hard = !u_val[19] && (u_val > $signed(two_w));
    div_ge = (num_r >= div_r);
    g2 = 22'(prod[63:16]) + 22'(prod[15]);
    rnd_sh = 6'(n_r) + 6'd13;
    tg_tmp = (40'(g_r) + (40'd1 << rnd_sh)) >> (rnd_sh + 6'd1);
    rom_addr = (state == L_RD1) ? RW'(idx_r + 1'b1) : prod[32 +: RW];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      L_POS: begin
        mul_a = x_frac;
        mul_b = 32'(LOG_TABLE_DEPTH);
      end
      L_INT: begin
        mul_a = 32'(rom_q - lo_r);
        mul_b = rem_r;
      end
      L_DB: begin
        mul_a = 32'(a_r);
        mul_b = DB_PER_LOG2;
      end
      K_SQ: begin
        mul_a = 32'(u_r);
        mul_b = 32'(u_r);
      end
      K_S: begin
        mul_a = prod[31:0];
        mul_b = 32'(cfg.ratio_slope);
      end
      H_MUL: begin
        mul_a = 32'(d_r[14:0]);
        mul_b = 32'(cfg.ratio_slope);
      end
      T_MUL: begin
        mul_a = 32'(gr_r);
        mul_b = LOG2_PER_DB;
      end
      E_STEP: begin
        mul_a = 32'(g_r);
        mul_b = 32'(exp_tab[k_r]);
      end
      V_M1: begin
        mul_a = 32'(c_r);
        mul_b = 32'(env);
      end
      V_M2: begin
        mul_a = 32'(17'd65536 - 17'(c_r));
        mul_b = 32'(tg_r);
      end
      V_TOT: begin
        mul_a = 32'(env);
        mul_b = 32'(cfg.makeup_gain);
      end
      O_L: begin
        mul_a = 32'(magl_r);
        mul_b = 32'(total_r);
      end
      O_R: begin
        mul_a = 32'(magr_r);
        mul_b = 32'(total_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    rom_q <= log_tab[rom_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      pass <= 1'b0;
      env <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (q_valid) begin
            magl_r <= q_data[2*SB-1:SB];
            lsign_r <= q_data[2*SB];
            magr_r <= q_data[3*SB:2*SB+1];
            rsign_r <= q_data[3*SB+1];
            pass <= 1'b0;
            e_r <= '0;
            norm <= NW'(q_peak) << (NW - SB);
            if (q_peak == '0) begin
              atten_r <= DB_FLOOR;
              state <= G_DIFF;
            end else begin
              state <= L_NORM;
            end
          end
        end
        L_NORM: begin
          if (norm[NW-1]) begin
            state <= L_POS;
          end else if (norm[NW-1:NW-4] == 4'b0) begin
            norm <= norm << 4;
            e_r <= e_r + 5'd4;
          end else begin
            norm <= norm << 1;
            e_r <= e_r + 5'd1;
          end
        end
        L_POS: state <= L_IDX;
        L_IDX: begin
          idx_r <= prod[32 +: RW];
          rem_r <= prod[31:0];
          state <= L_RD1;
        end
        L_RD1: begin
          lo_r <= rom_q;
          state <= L_INT;
        end
        L_INT: state <= L_FRAC;
        L_FRAC: begin
          a_r <= (21'(frac) > base) ? '0 : base - 21'(frac);
          state <= L_DB;
        end
        L_DB: state <= L_CLAMP;
        L_CLAMP: begin
          atten_r <= (db_val > 33'(DB_FLOOR)) ? DB_FLOOR : db_val[14:0];
          state <= pass ? DONE : G_DIFF;
        end
        G_DIFF: begin
          d_r <= d_next;
          state <= G_SEL;
        end
        G_SEL: begin
          u_r <= u_val[12:0];
          if (knee) begin
            state <= K_SQ;
          end else if (hard) begin
            state <= H_MUL;
          end else begin
            gr_r <= '0;
            state <= T_MUL;
          end
        end
        K_SQ: state <= K_S;
        K_S: state <= K_DIVI;
        K_DIVI: begin
          num_r <= 44'(prod[42:0]) + (44'(cfg.knee_width_db) << 18);
          div_r <= 44'(cfg.knee_width_db) << 30;
          quo_r <= '0;
          cnt_r <= '0;
          state <= K_DIV;
        end
        K_DIV: begin
          if (div_ge) begin
            num_r <= num_r - div_r;
          end
          div_r <= div_r >> 1;
          quo_r <= {quo_r[10:0], div_ge};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd11) begin
            gr_r <= 15'({quo_r[10:0], div_ge});
            state <= T_MUL;
          end
        end
        H_MUL: state <= H_RES;
        H_RES: begin
          gr_r <= 15'(prod[46:16] + 31'(prod[15]));
          state <= T_MUL;
        end
        T_MUL: state <= T_SPLIT;
        T_SPLIT: begin
          n_r <= g2[20:16];
          f_r <= g2[15:0];
          g_r <= 31'd1 << 30;
          k_r <= '0;
          state <= E_STEP;
        end
        E_STEP: begin
          if (f_r == '0) begin
            state <= E_SHIFT;
          end else if (f_r[15]) begin
            state <= E_ACC;
          end else begin
            f_r <= f_r << 1;
            k_r <= k_r + 4'd1;
          end
        end
        E_ACC: begin
          g_r <= 31'(prod[60:30] + 31'(prod[29]));
          f_r <= f_r << 1;
          k_r <= k_r + 4'd1;
          state <= E_STEP;
        end
        E_SHIFT: begin
          tg_r <= 17'(tg_tmp);
          state <= V_C;
        end
        V_C: begin
          c_r <= (tg_r < env) ? cfg.attack_coeff : cfg.release_coeff;
          state <= V_M1;
        end
        V_M1: state <= V_M2;
        V_M2: begin
          acc_r <= prod[33:0];
          state <= V_SUM;
        end
        V_SUM: begin
          env <= 17'((35'(acc_r) + 35'(prod[33:0]) + 35'd32768) >> 16);
          state <= V_TOT;
        end
        V_TOT: state <= V_TOTR;
        V_TOTR: begin
          total_r <= 21'(prod[32:12] + 21'(prod[11]));
          state <= O_L;
        end
        O_L: state <= O_R;
        O_R: begin
          left_r <= sat_out(prod, lsign_r);
          state <= O_RD;
        end
        O_RD: begin
          right_r <= sat_out(prod, rsign_r);
          pass <= 1'b1;
          e_r <= '0;
          norm <= NW'(env) << (NW - 17);
          if (env == '0) begin
            atten_r <= DB_FLOOR;
            state <= DONE;
          end else begin
            state <= L_NORM;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            left_out <= left_r;
            right_out <= right_r;
            gr_out <= atten_r;
            out_valid <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/skc_checker.sv =====
// Port-level checks for the compressor, bound to the top level.
module skc_checker
  import skc_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((2*SAMPLE_BITS+15+7)/8)*8-1:0] m_tdata
);

  logic [14:0]            gr;
  logic [SAMPLE_BITS-1:0] lo;
  logic [SAMPLE_BITS-1:0] ro;

  assign lo = m_tdata[SAMPLE_BITS-1:0];
  assign ro = m_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign gr = m_tdata[2*SAMPLE_BITS+14:2*SAMPLE_BITS];

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_gr_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> gr <= DB_FLOOR)
    else $error("gain reduction beyond floor");

  a_mute: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && gr == DB_FLOOR |-> lo == '0 && ro == '0)
    else $error("output not muted at floor gain");

endmodule

bind soft_knee_linked_stereo_compressor skc_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_skc_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

// ===== tb/soft_knee_linked_stereo_compressor_tb.sv =====
// Self-checking testbench for the soft-knee linked stereo compressor.
`timescale 1ns / 100ps

module soft_knee_linked_stereo_compressor_tb;
  import skc_pkg::*;

  localparam int SB = 24;
  localparam int LD = 64;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam logic [23:0] MAXS = 24'h7FFFFF;
  localparam logic [23:0] MINS = 24'h800000;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE = 150;

  typedef struct packed {
    logic [23:0] l;
    logic [23:0] r;
    logic [14:0] gr;
  } gained_t;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  idx;
    logic [15:0] val;
    logic [23:0] l;
    logic [23:0] r;
    logic        known;
    gained_t     res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #2 clk = ~clk;

  soft_knee_linked_stereo_compressor u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // compressor model state
  longint unsigned log_rom [LD+1];
  longint unsigned exp_rom [16];
  logic [14:0] thr_q;
  logic [15:0] slope_q, attack_q, release_q, makeup_q;
  logic [11:0] knee_q;
  logic [16:0] env_q;

  gained_t pending_gain [$];
  int mismatches = 0;
  int idle_cycles = 0;
  int burst_left = 1;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void build_tables();
    longint unsigned y, acc, c;
    for (int i = 0; i < LD; i++) begin
      y = ((longint'(LD) + i) << 30) / LD;
      acc = 0;
      for (int k = 0; k < 16; k++) begin
        y = (y * y) >> 30;
        acc <<= 1;
        if (y >= (64'd1 << 31)) begin
          acc |= 1;
          y >>= 1;
        end
      end
      log_rom[i] = acc;
    end
    log_rom[LD] = 65536;
    c = int_sqrt(64'd1 << 59);
    for (int k = 0; k < 16; k++) begin
      exp_rom[k] = c;
      c = int_sqrt(c << 30);
    end
  endfunction

  function automatic longint unsigned atten_db(longint unsigned mag, int fsb);
    int m;
    longint unsigned x, pos, idx, rem, frac, a;
    m = 0;
    if (mag == 0) return DB_FLOOR;
    while ((mag >> (m + 1)) != 0) m++;
    if (m > fsb) return 0;
    x = ((mag - (64'd1 << m)) << (32 - m)) & 64'hFFFF_FFFF;
    pos = x * LD;
    idx = pos >> 32;
    rem = pos & 64'hFFFF_FFFF;
    frac = log_rom[idx] + (((log_rom[idx+1] - log_rom[idx]) * rem) >> 32);
    if (longint'(fsb - m) * 65536 < frac) return 0;
    a = longint'(fsb - m) * 65536 - frac;
    a = (a * DB_PER_LOG2 + (64'd1 << 31)) >> 32;
    return (a > DB_FLOOR) ? DB_FLOOR : a;
  endfunction

  function automatic longint unsigned gain_from_reduction(longint unsigned gr);
    longint unsigned g2, n, f, g;
    g2 = (gr * LOG2_PER_DB + 32768) >> 16;
    n = g2 >> 16;
    f = g2 & 16'hFFFF;
    g = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if ((f >> (15 - k)) & 1) g = (g * exp_rom[k] + (64'd1 << 29)) >> 30;
    if (n > 40) return 0;
    return (g + (64'd1 << (13 + n))) >> (14 + n);
  endfunction

  function automatic logic [23:0] apply_gain(longint s, longint unsigned total);
    longint unsigned mag, q;
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q = (mag * total + 32768) >> 16;
    if (s < 0) return (q > 64'h800000) ? MINS : 24'(-longint'(q));
    return (q > 64'h7FFFFF) ? MAXS : 24'(q);
  endfunction

  function automatic gained_t compress_pair(logic [23:0] ls, logic [23:0] rs);
    longint l, r, lvl, t, w, u;
    longint unsigned peak, gr, tg, c, total, den;
    gained_t o;
    l = longint'($signed(ls));
    r = longint'($signed(rs));
    peak = (l < 0 ? -l : l) > (r < 0 ? -r : r) ? (l < 0 ? -l : l) : (r < 0 ? -r : r);
    lvl = -longint'(atten_db(peak, SB - 1));
    t = longint'($signed(thr_q));
    w = longint'(knee_q);
    u = 2 * (lvl - t) + w;
    gr = 0;
    if (w > 0 && u >= 0 && u <= 2 * w) begin
      den = w * 8 * 65536;
      gr = (longint'(slope_q) * u * u + den / 2) / den;
    end else if (u > 2 * w) begin
      gr = ((lvl - t) * longint'(slope_q) + 32768) >> 16;
    end
    tg = gain_from_reduction(gr);
    c = (tg < env_q) ? attack_q : release_q;
    env_q = 17'((c * env_q + (65536 - c) * tg + 32768) >> 16);
    total = (longint'(env_q) * makeup_q + 2048) >> 12;
    o.l = apply_gain(l, total);
    o.r = apply_gain(r, total);
    o.gr = 15'(atten_db(env_q, 16));
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_THRESHOLD: thr_q = val[14:0];
      REG_RATIO:     slope_q = val;
      REG_KNEE:      knee_q = val[11:0];
      REG_ATTACK:    attack_q = val;
      REG_RELEASE:   release_q = val;
      REG_MAKEUP:    makeup_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (pending_gain.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_pair(logic [23:0] l, logic [23:0] r, logic known, gained_t fixed);
    gained_t e;
    int gap;
    s_tvalid <= 1;
    s_tdata <= {r, l};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    e = compress_pair(l, r);
    pending_gain = {pending_gain, known ? fixed : e};
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [23:0] rand_sample();
    logic signed [23:0] v;
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return MAXS;
      2: return MINS;
      default: begin
        v = 24'($urandom);
        return v >>> $urandom_range(0, 22);
      end
    endcase
  endfunction

  function automatic logic [15:0] pick(int lo, int hi, int mode);
    if (mode == 0) return 16'(lo);
    if (mode == 1) return 16'(hi);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  row_t dir_tab [] = '{
    '{1'b0, 3'd0, 16'd0, 24'd0, 24'd0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, MAXS, MAXS, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, MINS, MINS, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, MINS, 24'd1, 1'b0, '0},
    '{1'b1, REG_ATTACK, 16'd0, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_RELEASE, 16'd0, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_MAKEUP, 16'd65535, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_RATIO, 16'd0, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_KNEE, 16'd0, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_THRESHOLD, 16'd0, 24'd0, 24'd0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 24'd0, 24'd0, 1'b1, '{24'd0, 24'd0, 15'd0}},
    '{1'b0, 3'd0, 16'd0, MAXS, MINS, 1'b1, '{MAXS, MINS, 15'd0}},
    '{1'b1, REG_MAKEUP, 16'd4096, 24'd0, 24'd0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 24'h123456, 24'hABCDEF, 1'b1, '{24'h123456, 24'hABCDEF, 15'd0}},
    '{1'b0, 3'd0, 16'd0, MINS, MAXS, 1'b1, '{MINS, MAXS, 15'd0}},
    '{1'b1, REG_RATIO, 16'd62259, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_THRESHOLD, 16'hC400, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_KNEE, 16'd3072, 24'd0, 24'd0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, MAXS, 24'd0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 24'h000100, 24'hFFFF00, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_UNUSED, 16'hFFFF, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_THRESHOLD, 16'h3FFF, 24'd0, 24'd0, 1'b0, '0},
    '{1'b1, REG_RATIO, 16'hFFFF, 24'd0, 24'd0, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, MAXS, MAXS, 1'b0, '0},
    '{1'b0, 3'd0, 16'd0, MINS, 24'd0, 1'b0, '0}
  };

  initial begin
    logic prev_cfg;
    int mode;
    build_tables();
    thr_q = THRESHOLD_RESET;
    slope_q = RATIO_RESET;
    knee_q = KNEE_RESET;
    attack_q = ATTACK_RESET;
    release_q = RELEASE_RESET;
    makeup_q = MAKEUP_RESET;
    env_q = '0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    prev_cfg = 0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!prev_cfg) wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        if (prev_cfg) cfg_we <= 0;
        send_pair(dir_tab[i].l, dir_tab[i].r, dir_tab[i].known, dir_tab[i].res);
      end
      prev_cfg = dir_tab[i].is_cfg;
    end
    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      mode = ph < 2 ? ph : 2;
      write_reg(REG_THRESHOLD, pick(-15360, 0, mode == 2 ? 2 : 1 - mode));
      write_reg(REG_RATIO, pick(0, 62259, mode));
      write_reg(REG_KNEE, ph == 3 ? 16'd0 : pick(0, 3072, mode));
      write_reg(REG_ATTACK, pick(0, 65535, mode));
      write_reg(REG_RELEASE, pick(0, 65535, mode));
      write_reg(REG_MAKEUP, pick(4096, 65535, mode));
      cfg_we <= 0;
      for (int n = 0; n < 200; n++) send_pair(rand_sample(), rand_sample(), 1'b0, '0);
    end
    s_tvalid <= 0;
    while (pending_gain.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  // receiver stall pattern, with two long hold-offs
  int rx_cycle = 0;
  int rx_hold = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 50 == 0) rx_mode <= $urandom_range(0, 2);
    if (rx_cycle == 3000 || rx_cycle == 40000) begin
      rx_hold <= 500;
      m_tready <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(negedge clk) begin
    gained_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[23:0], m_tdata[47:24], m_tdata[62:48]};
      if (pending_gain.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected request out: %h", got);
      end else begin
        want = pending_gain.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: l %h/%h r %h/%h gr %0d/%0d (exp/got)",
                     want.l, got.l, want.r, got.r, want.gr, got.gr);
        end
      end
    end
  end

  always @(negedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
